// File: design/shacmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shacmp_pkg
// Shared types, constants and round functions of the SHA-256 block
// compressor.
// ----------------------------------------------------------------------------
package shacmp_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned HASH_WORDS  = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        word_idx_t;
  typedef logic [5:0]        round_idx_t;
  typedef logic [2:0]        hash_idx_t;

  localparam word_idx_t  LAST_WORD  = word_idx_t'(BLOCK_WORDS - 1);
  localparam round_idx_t LAST_ROUND = round_idx_t'(ROUNDS - 1);
  localparam hash_idx_t  LAST_HASH  = hash_idx_t'(HASH_WORDS - 1);

  typedef struct packed {
    logic       load_word;
    logic       init_hash;
    logic       start;
    logic       round_en;
    logic       update;
    round_idx_t round_idx;
    hash_idx_t  out_idx;
  } cmd_t;

  localparam word_t INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: design/shacmp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shacmp_dp
// Datapath: message schedule shift line, working variables, round logic and
// chaining value.
// ----------------------------------------------------------------------------
module shacmp_dp (
  input  wire                     clk,
  input  wire                     rst,
  input  shacmp_pkg::cmd_t        cmd,
  input  shacmp_pkg::word_t       message_word,
  output shacmp_pkg::word_t       digest_word
);

  shacmp_pkg::word_t hash [shacmp_pkg::HASH_WORDS];
  shacmp_pkg::word_t vars [shacmp_pkg::HASH_WORDS];
  shacmp_pkg::word_t sched [shacmp_pkg::BLOCK_WORDS];

  shacmp_pkg::word_t sched_new;
  shacmp_pkg::word_t sched_in;
  shacmp_pkg::word_t t1;
  shacmp_pkg::word_t t2;
  shacmp_pkg::word_t ch;
  shacmp_pkg::word_t maj;

  always_comb begin
    sched_new = shacmp_pkg::small_sigma1(sched[14]) + sched[9]
              + shacmp_pkg::small_sigma0(sched[1]) + sched[0];
    sched_in  = cmd.load_word ? message_word : sched_new;
    ch        = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj       = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1        = vars[7] + shacmp_pkg::big_sigma1(vars[4]) + ch
              + shacmp_pkg::ROUND_K[cmd.round_idx] + sched[0];
    t2        = shacmp_pkg::big_sigma0(vars[0]) + maj;
  end

  // Shift the schedule window on each loaded word and on each round.
  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round_en) begin
      for (int i = 0; i < shacmp_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[shacmp_pkg::BLOCK_WORDS-1] <= sched_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < shacmp_pkg::HASH_WORDS; i++) begin
        hash[i] <= shacmp_pkg::INIT_HASH[i];
        vars[i] <= '0;
      end
    end else begin
      if (cmd.init_hash) begin
        for (int i = 0; i < shacmp_pkg::HASH_WORDS; i++) begin
          hash[i] <= shacmp_pkg::INIT_HASH[i];
        end
      end else if (cmd.update) begin
        for (int i = 0; i < shacmp_pkg::HASH_WORDS; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end
      if (cmd.start) begin
        for (int i = 0; i < shacmp_pkg::HASH_WORDS; i++) begin
          vars[i] <= hash[i];
        end
      end else if (cmd.round_en) begin
        vars[7] <= vars[6];
        vars[6] <= vars[5];
        vars[5] <= vars[4];
        vars[4] <= vars[3] + t1;
        vars[3] <= vars[2];
        vars[2] <= vars[1];
        vars[1] <= vars[0];
        vars[0] <= t1 + t2;
      end
    end
  end

  assign digest_word = hash[cmd.out_idx];

endmodule

`default_nettype wire

// File: design/shacmp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shacmp_ctrl
// Controller: word, round and digest counters and the block sequence.
// ----------------------------------------------------------------------------
module shacmp_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire                  first_block,
  input  wire                  last_block,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic                 m_tlast,
  output shacmp_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_ROUND  = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  shacmp_pkg::word_idx_t  word_count;
  shacmp_pkg::round_idx_t round_count;
  shacmp_pkg::hash_idx_t  emit_idx;
  logic                   last_flag;
  logic                   in_beat;
  logic                   out_beat;

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tlast  = (emit_idx == shacmp_pkg::LAST_HASH);
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  always_comb begin
    cmd           = '0;
    cmd.load_word = in_beat;
    cmd.init_hash = in_beat && first_block && (word_count == '0);
    cmd.start     = in_beat && (word_count == shacmp_pkg::LAST_WORD);
    cmd.round_en  = (state == ST_ROUND);
    cmd.update    = (state == ST_UPDATE);
    cmd.round_idx = round_count;
    cmd.out_idx   = emit_idx;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_beat && (word_count == shacmp_pkg::LAST_WORD)) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_count == shacmp_pkg::LAST_ROUND) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = last_flag ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (out_beat && (emit_idx == shacmp_pkg::LAST_HASH)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      word_count  <= '0;
      round_count <= '0;
      emit_idx    <= '0;
      last_flag   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        word_count <= word_count + 1'b1;
        if (word_count == shacmp_pkg::LAST_WORD) last_flag <= last_block;
      end
      if (state == ST_ROUND) round_count <= round_count + 1'b1;
      if (out_beat) emit_idx <= emit_idx + 1'b1;
    end
  end

  a_round_start: assert property (@(posedge clk) disable iff (rst)
    (in_beat && (word_count == shacmp_pkg::LAST_WORD))
      |=> (state == ST_ROUND && round_count == '0))
    else $error("rounds did not start from round zero");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_count == shacmp_pkg::LAST_ROUND) |=> (state == ST_UPDATE))
    else $error("no update after the last round");

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && last_flag) |=> (state == ST_EMIT && emit_idx == '0))
    else $error("digest did not start at word zero");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (out_beat && emit_idx == shacmp_pkg::LAST_HASH) |=> (state == ST_LOAD && word_count == '0))
    else $error("block load not resumed after digest");

endmodule

`default_nettype wire

// File: design/sha256_block_compressor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_block_compressor_unit
// SHA-256 compression of a padded message streamed as 32-bit words, with the
// digest streamed out after the last block.
//
//   channel  dir  payload
//   s_axis   in   tdata: message_word; tuser: first_block, last_block
//   m_axis   out  tdata: digest_word, digest_index; tlast: digest_last
//
// A block takes 16 word beats, 64 rounds at one round per cycle in the
// shared round unit, and a fold of the working variables into the
// chaining value. A last block adds 8 digest beats, one per cycle unstalled.
// Input is held off during rounds, the fold and digest output; the digest
// holds while m_axis_tready is low. Reset loads the standard initial hash.
// ----------------------------------------------------------------------------
module sha256_block_compressor_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] message_word
  input  wire  [1:0]  s_axis_tuser,   // [0] first_block, [1] last_block
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_index
  output logic        m_axis_tlast
);

  shacmp_pkg::cmd_t  cmd;
  shacmp_pkg::word_t digest_word;

  shacmp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .first_block (s_axis_tuser[0]),
    .last_block  (s_axis_tuser[1]),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tlast     (m_axis_tlast),
    .cmd         (cmd)
  );

  shacmp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_word (s_axis_tdata),
    .digest_word  (digest_word)
  );

  assign m_axis_tdata = {5'b00000, cmd.out_idx, digest_word};

endmodule

`default_nettype wire

// File: verif/sha256_block_compressor_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_block_compressor_unit_test
// Self-checking bench for the SHA-256 block compressor. Streams padded
// blocks into s_axis, predicts each digest from its own model of the
// schedule, round and chaining-value update, and checks every m_axis beat.
// A short directed table covers a known digest and the ignored flag cases.
// Random messages follow over four phases of source idling and sink stalls.
// ----------------------------------------------------------------------------
module sha256_block_compressor_unit_test;

  typedef shacmp_pkg::word_t word_t;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // digest of the one-block message "abc"
  localparam word_t ABC_DIGEST [8] = '{
    32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
    32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
  };

  typedef struct packed {
    word_t w;
    logic  first;
    logic  last;
    logic  known;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 32;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // "abc", first also on word 7 and last also on word 3: both ignored
    '{32'h61626380, 1'b1, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b1, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000018, 1'b0, 1'b1, 1'b1},
    // continue from the digest: first only on word 9, last on words 0 and 14, not 15
    '{32'hffffffff, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h80000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000001, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b1, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0}
  };

  typedef struct {
    word_t    dword;
    logic [2:0] idx;
    logic     dlast;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] message_word
  logic [1:0]  s_axis_tuser = '0;   // [0] first_block, [1] last_block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] digest_word, [34:32] digest_index
  logic        m_axis_tlast;

  word_t        chain_hash [8];
  word_t        block_words [16];
  logic [3:0]   word_pos = '0;
  digest_beat_t digest_q [$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_stall_pct = 0;
  logic         msg_done = 1'b1;

  sha256_block_compressor_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t sch [64];
    word_t v [8];
    word_t t1;
    word_t t2;
    for (int t = 0; t < 16; t++) sch[t] = block_words[t];
    for (int t = 16; t < 64; t++) begin
      sch[t] = sch[t-16] + sch[t-7]
             + (ror(sch[t-15], 7) ^ ror(sch[t-15], 18) ^ (sch[t-15] >> 3))
             + (ror(sch[t-2], 17) ^ ror(sch[t-2], 19) ^ (sch[t-2] >> 10));
    end
    v = chain_hash;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + sch[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
  endfunction

  // advance the model by one accepted word; queue the digest after a last block
  function automatic void absorb_message_word(input word_t w, input logic first,
                                              input logic last, input logic known);
    digest_beat_t beat;
    if (word_pos == 4'd0 && first) chain_hash = SHA_IV;
    block_words[word_pos] = w;
    if (word_pos == 4'd15) begin
      compress_block();
      if (last) begin
        for (int i = 0; i < 8; i++) begin
          beat.dword = known ? ABC_DIGEST[i] : chain_hash[i];
          beat.idx = 3'(i);
          beat.dlast = (i == 7);
          digest_q.push_back(beat);
        end
      end
    end
    word_pos = word_pos + 4'd1;
  endfunction

  task automatic send_word(input word_t w, input logic first, input logic last,
                           input logic known);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= {last, first};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    absorb_message_word(w, first, last, known);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (digest_q.size() != 0);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h00000000;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_blocks(input int unsigned n_blocks);
    logic first;
    logic last;
    for (int b = 0; b < n_blocks; b++) begin
      for (int k = 0; k < 16; k++) begin
        if (k == 0)
          first = msg_done ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 7) == 0);
        else
          first = ($urandom_range(0, 7) == 0);
        if (k == 15)
          last = ($urandom_range(0, 2) != 0);
        else
          last = ($urandom_range(0, 7) == 0);
        send_word(pick_word(), first, last, 1'b0);
        if (k == 15) msg_done = last;
      end
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : check_digest
    digest_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest beat: data %h last %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata[31:0] !== want.dword) begin
          $error("digest_word: expected %h, got %h", want.dword, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[34:32] !== want.idx) begin
          $error("digest_index: expected %0d, got %0d", want.idx, m_axis_tdata[34:32]);
          errors++;
        end
        if (m_axis_tlast !== want.dlast) begin
          $error("digest_last: expected %b, got %b", want.dlast, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    chain_hash = SHA_IV;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(DIRECTED[i].w, DIRECTED[i].first, DIRECTED[i].last, DIRECTED[i].known);
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
        default: begin src_idle_pct = 19; snk_stall_pct = 19; end
      endcase
      run_blocks(ph == 0 ? 4 : 5);
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
